### rtl/iprtc_pkg.sv
// ----------------------------------------------------------------------------
// IP rule table classifier package
// Shared types, field layouts and codes for the first-match rule table.
// ----------------------------------------------------------------------------
package iprtc_pkg;

  // Default table depth.
  localparam int unsigned MAX_RULES_DEF = 16;

  // Width of the reported slot number.
  localparam int unsigned SLOT_W = 4;

  // Stream data widths, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 8;

  // Item kinds carried on the input tuser bit.
  localparam logic CMD_ADD      = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  // Rule action codes. The fourth code is unused and never gives a verdict.
  localparam logic [1:0] ACT_ACCEPT = 2'd0;
  localparam logic [1:0] ACT_DROP   = 2'd1;
  localparam logic [1:0] ACT_LOG    = 2'd2;

  // Input tdata layout, last field in the lowest bits.
  typedef struct packed {
    logic [2:0]  pad;
    logic [1:0]  action;
    logic        use_proto;
    logic        use_dst;
    logic        use_src;
    logic [7:0]  protocol;
    logic [31:0] dst_addr;
    logic [31:0] src_addr;
  } in_data_t;

  // Output tdata layout, last field in the lowest bits.
  typedef struct packed {
    logic              table_full;
    logic [SLOT_W-1:0] rule_slot;
    logic              matched;
    logic              log_header;
    logic              verdict;
  } out_data_t;

  // One stored rule.
  typedef struct packed {
    logic [1:0]  action;
    logic        use_proto;
    logic        use_dst;
    logic        use_src;
    logic [7:0]  protocol;
    logic [31:0] dst_addr;
    logic [31:0] src_addr;
  } rule_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // take the accepted item
    logic step;      // read the next rule, newest first
    logic compare;   // evaluate the rule read in the previous cycle
    logic out_load;  // move the finished result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_search;  // the item on the input needs a table search
    logic cmp_done;      // the search found a rule or reached slot zero
    logic out_free;      // the output register can take a result
  } dp_sts_t;

endpackage

### rtl/iprtc_ctrl.sv
// ----------------------------------------------------------------------------
// IP rule table classifier controller
// Sequences accept, table search and result hand-off for one item at a time.
// ----------------------------------------------------------------------------
module iprtc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  iprtc_pkg::dp_sts_t sts_i,
  output iprtc_pkg::dp_cmd_t cmd_o
);
  import iprtc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_RESULT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Next state and datapath commands.
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.start_search ? ST_SEARCH : ST_RESULT;
        end
      end
      ST_SEARCH: begin
        cmd_o.step    = 1'b1;
        cmd_o.compare = 1'b1;
        if (sts_i.cmp_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // An accepted transaction always leaves the idle state.
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("controller stayed idle after an accepted transaction");

  // A result is handed to the output register only when it is free.
  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded while the output register was busy");

  // A search only ends through the result state.
  a_search_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) && sts_i.cmp_done |=> (state_q == ST_RESULT))
    else $error("search did not move to the result state");

endmodule

### rtl/iprtc_dp.sv
// ----------------------------------------------------------------------------
// IP rule table classifier datapath
// Rule memory, fill count, search index, rule compare and output register.
// ----------------------------------------------------------------------------
module iprtc_dp #(
  parameter int unsigned MAX_RULES = iprtc_pkg::MAX_RULES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [iprtc_pkg::IN_TDATA_W-1:0]    in_data_i,
  input  logic                                in_cmd_i,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [iprtc_pkg::OUT_TDATA_W-1:0]   out_data_o,
  input  iprtc_pkg::dp_cmd_t                  cmd_i,
  output iprtc_pkg::dp_sts_t                  sts_o
);
  import iprtc_pkg::*;

  localparam int unsigned IDXW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned CNTW = $clog2(MAX_RULES + 1);

  in_data_t        in_d;
  rule_t           wr_rule;
  logic            is_add;
  logic            add_ok;
  logic            wr_en;

  logic            filt_en_q;
  logic [CNTW-1:0] cnt_q;
  logic [IDXW-1:0] idx_q;
  logic [31:0]     key_src_q;
  logic [31:0]     key_dst_q;
  logic [7:0]      key_proto_q;

  rule_t           mem [MAX_RULES];
  rule_t           rd_rule_q;
  logic            rd_vld_q;
  logic [IDXW-1:0] rd_slot_q;

  logic            rule_match;
  logic            act_valid;
  logic            hit;
  logic [SLOT_W+IDXW-1:0] slot_wide;

  out_data_t       res_init;
  out_data_t       res_hit;
  out_data_t       res_q;
  logic            out_valid_q;
  out_data_t       out_data_q;

  assign in_d   = in_data_t'(in_data_i);
  assign is_add = (in_cmd_i == CMD_ADD);
  assign add_ok = (cnt_q < CNTW'(MAX_RULES));
  assign wr_en  = cmd_i.load && is_add && add_ok;

  assign wr_rule.src_addr  = in_d.src_addr;
  assign wr_rule.dst_addr  = in_d.dst_addr;
  assign wr_rule.protocol  = in_d.protocol;
  assign wr_rule.use_src   = in_d.use_src;
  assign wr_rule.use_dst   = in_d.use_dst;
  assign wr_rule.use_proto = in_d.use_proto;
  assign wr_rule.action    = in_d.action;

  // Filter enable register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      filt_en_q <= cfg_wdata_i;
    end
  end

  // Rule count: one more for each add that fits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (wr_en) begin
      cnt_q <= cnt_q + CNTW'(1);
    end
  end

  // Packet key and search index; the index walks down and holds at zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_src_q   <= in_d.src_addr;
      key_dst_q   <= in_d.dst_addr;
      key_proto_q <= in_d.protocol;
      idx_q       <= IDXW'(cnt_q - CNTW'(1));
    end else if (cmd_i.step) begin
      idx_q <= (idx_q == '0) ? '0 : idx_q - IDXW'(1);
    end
  end

  // Rule memory with registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[IDXW-1:0]] <= wr_rule;
    end
    if (cmd_i.step) begin
      rd_rule_q <= mem[idx_q];
      rd_slot_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.step;
    end
  end

  // Compare the rule read in the previous cycle against the packet key.
  assign rule_match = (!rd_rule_q.use_src   || (rd_rule_q.src_addr == key_src_q)) &&
                      (!rd_rule_q.use_dst   || (rd_rule_q.dst_addr == key_dst_q)) &&
                      (!rd_rule_q.use_proto || (rd_rule_q.protocol == key_proto_q));
  assign act_valid  = (rd_rule_q.action == ACT_ACCEPT) || (rd_rule_q.action == ACT_DROP) ||
                      (rd_rule_q.action == ACT_LOG);
  assign hit        = rd_vld_q && rule_match && act_valid;
  assign slot_wide  = {{SLOT_W{1'b0}}, rd_slot_q};

  // Result values for a fresh transaction and for the first hit.
  always_comb begin
    res_init            = '0;
    res_init.table_full = is_add && !add_ok;
    res_hit             = res_q;
    res_hit.matched     = 1'b1;
    res_hit.verdict     = (rd_rule_q.action == ACT_DROP);
    res_hit.log_header  = (rd_rule_q.action == ACT_LOG);
    res_hit.rule_slot   = slot_wide[SLOT_W-1:0];
  end

  // Pending result: cleared on accept, filled by the first hit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q <= res_init;
    end else if (cmd_i.compare && hit) begin
      res_q <= res_hit;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Status toward the controller.
  assign sts_o.start_search = (in_cmd_i == CMD_CLASSIFY) && filt_en_q && (cnt_q != '0);
  assign sts_o.cmp_done     = rd_vld_q && (hit || (rd_slot_q == '0));
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  // The table never holds more rules than it has slots.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(MAX_RULES))
    else $error("rule count above table depth");

  // The count only moves after an accepted add that fit.
  a_cnt_moves_on_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> $past(wr_en))
    else $error("rule count changed without an add");

  // A result never drops and logs at once.
  a_verdict_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q.verdict && out_data_q.log_header))
    else $error("result both drops and logs");

endmodule

### rtl/ip_rule_table_classifier_core.sv
// ----------------------------------------------------------------------------
// IP rule table classifier
// First-match IPv4 rule table: adds rules at top priority and classifies
// packet headers against them from newest to oldest.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  s_axis    in         tuser: cmd; tdata: rule or packet header fields
//  m_axis    out        tdata: verdict, log_header, matched, rule_slot, table_full
//  cfg       in         cfg_we_i / cfg_wdata_i: filter_enable
//
//  An add, or a classify that needs no search, passes from accept through the
//  result state into the output register. A classify with filtering enabled
//  and stored rules first searches: the search reads one rule per cycle
//  from the single-port rule memory and stops at the first hit.
//  Reset clears the rule count, the filter enable and all handshake state;
//  the rule memory itself is not cleared. A stalled output holds its result
//  while the next transaction is already accepted and worked on.
// ----------------------------------------------------------------------------
module ip_rule_table_classifier_core #(
  parameter int unsigned MAX_RULES = iprtc_pkg::MAX_RULES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata from bit 0: src_addr[31:0], dst_addr[31:0], protocol[7:0], use_src,
  // use_dst, use_proto, action[1:0], zero padding[2:0].
  input  logic [iprtc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: cmd.
  input  logic                              s_axis_tuser,
  // Output stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata from bit 0: verdict, log_header, matched, rule_slot[3:0], table_full.
  output logic [iprtc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration.
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i
);
  import iprtc_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Controller.
  iprtc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (dp_sts),
    .cmd_o         (dp_cmd)
  );

  // Datapath.
  iprtc_dp #(
    .MAX_RULES (MAX_RULES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_cmd_i    (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts)
  );

endmodule

### bench/ip_rule_table_classifier_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP rule table classifier testbench
// Drives rule adds and packet headers into the stream input under random
// source gaps and sink stalls, predicts every verdict with a behavioral model
// of the first-match table and checks each output transaction against it.
// ----------------------------------------------------------------------------
module ip_rule_table_classifier_core_test;
  import iprtc_pkg::*;

  localparam int unsigned TABLE_DEPTH  = MAX_RULES_DEF;
  localparam logic [1:0]  ACT_UNUSED   = 2'd3;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 280;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS  = 10;

  // One queued input transaction: the kind on tuser and the packed fields.
  typedef struct packed {
    logic     cmd;
    in_data_t data;
  } hdr_item_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i = 1'b0;
  logic                   cfg_wdata_i = 1'b0;

  // Behavioral copy of the rule table and the enable register.
  rule_t       rule_mem [TABLE_DEPTH];
  int unsigned rule_cnt = 0;
  logic        filter_on = 1'b0;

  // Rules in table order as generated, used to aim packets at stored rules.
  in_data_t    gen_rules [$];
  hdr_item_t   header_q [$];
  out_data_t   verdict_q [$];

  logic [31:0] addr_pool [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0A00_0001,
                                 32'hC0A8_0001};

  int unsigned queued_cnt = 0, accepted_cnt = 0, checked_cnt = 0, err_cnt = 0;
  int unsigned n_add = 0, n_full = 0, n_match = 0, n_drop = 0, n_log = 0;
  int unsigned cfg_cnt = 0;

  // Driver and monitor handshake state.
  hdr_item_t cur_hdr;
  bit        sent = 1'b0, took = 1'b0;
  int        gap_left = 0, src_calm = 0, stall_left = 0, snk_calm = 0;

  ip_rule_table_classifier_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Wait cycles for one transaction, with occasional stretches of no waiting.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 9);
  endfunction

  // Applies one accepted transaction to the table copy and returns its result.
  function automatic out_data_t predict_verdict(hdr_item_t it);
    out_data_t res;
    rule_t     r;
    int        k;
    logic      found;
    res = '0;
    found = 1'b0;
    if (it.cmd == CMD_ADD) begin
      if (rule_cnt >= TABLE_DEPTH) begin
        res.table_full = 1'b1;
      end else begin
        r.src_addr  = it.data.src_addr;
        r.dst_addr  = it.data.dst_addr;
        r.protocol  = it.data.protocol;
        r.use_src   = it.data.use_src;
        r.use_dst   = it.data.use_dst;
        r.use_proto = it.data.use_proto;
        r.action    = it.data.action;
        rule_mem[rule_cnt] = r;
        rule_cnt++;
      end
    end else if (filter_on) begin
      // Newest rule first; a hit on the unused action code keeps searching.
      for (k = int'(rule_cnt) - 1; k >= 0 && !found; k--) begin
        r = rule_mem[k];
        if ((!r.use_src || r.src_addr == it.data.src_addr) &&
            (!r.use_dst || r.dst_addr == it.data.dst_addr) &&
            (!r.use_proto || r.protocol == it.data.protocol) &&
            r.action != ACT_UNUSED) begin
          found          = 1'b1;
          res.matched    = 1'b1;
          res.verdict    = (r.action == ACT_DROP);
          res.log_header = (r.action == ACT_LOG);
          res.rule_slot  = SLOT_W'(k);
        end
      end
    end
    return res;
  endfunction

  function automatic in_data_t hdr_fields(logic [31:0] src, logic [31:0] dst,
                                          logic [7:0] proto, logic us, logic ud,
                                          logic up, logic [1:0] act);
    in_data_t d;
    d           = '0;
    d.src_addr  = src;
    d.dst_addr  = dst;
    d.protocol  = proto;
    d.use_src   = us;
    d.use_dst   = ud;
    d.use_proto = up;
    d.action    = act;
    return d;
  endfunction

  function automatic logic [31:0] pick_addr();
    if ($urandom_range(0, 1) != 0) return addr_pool[$urandom_range(0, 3)];
    return $urandom();
  endfunction

  // Random rule; a shared address pool makes rules overlap.
  function automatic in_data_t make_rule();
    logic [7:0] proto;
    proto = ($urandom_range(0, 1) != 0) ? 8'd6 : 8'($urandom_range(0, 255));
    return hdr_fields(pick_addr(), pick_addr(), proto, 1'($urandom()),
                      1'($urandom()), 1'($urandom()), 2'($urandom_range(0, 3)));
  endfunction

  // Mostly headers copied from a stored rule with an occasional flipped bit,
  // the rest free-running noise.
  function automatic in_data_t make_packet();
    in_data_t d;
    int       b;
    if (gen_rules.size() > 0 && $urandom_range(0, 3) != 0) begin
      d = gen_rules[$urandom_range(0, gen_rules.size() - 1)];
      if ($urandom_range(0, 5) == 0) begin
        b = $urandom_range(0, 31);
        d.src_addr[b] = ~d.src_addr[b];
      end
      if ($urandom_range(0, 5) == 0) begin
        b = $urandom_range(0, 31);
        d.dst_addr[b] = ~d.dst_addr[b];
      end
      if ($urandom_range(0, 5) == 0) begin
        b = $urandom_range(0, 7);
        d.protocol[b] = ~d.protocol[b];
      end
    end else begin
      d = hdr_fields(pick_addr(), pick_addr(), 8'($urandom_range(0, 255)),
                     1'b0, 1'b0, 1'b0, ACT_ACCEPT);
    end
    // Rule-only fields are don't-care on a classify and get random values.
    d.use_src   = 1'($urandom());
    d.use_dst   = 1'($urandom());
    d.use_proto = 1'($urandom());
    d.action    = 2'($urandom_range(0, 3));
    d.pad       = '0;
    return d;
  endfunction

  task automatic push_item(input logic cmd, input in_data_t d);
    header_q.push_back({cmd, d});
    queued_cnt++;
    if (cmd == CMD_ADD && gen_rules.size() < TABLE_DEPTH) gen_rules.push_back(d);
  endtask

  // Returns at a falling edge once every queued transaction has its result.
  task automatic wait_idle();
    @(negedge clk_i);
    while (!(header_q.size() == 0 && accepted_cnt == queued_cnt &&
             verdict_q.size() == 0))
      @(negedge clk_i);
  endtask

  task automatic set_filter(input logic en);
    wait_idle();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = en;
    filter_on   = en;
    cfg_cnt++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Source side: present queued transactions with random gaps between them.
  always @(negedge clk_i) begin : drive_proc
    logic nv;
    if (rst_ni) begin
      nv = s_axis_tvalid;
      if (sent) begin
        sent = 1'b0;
        nv   = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (header_q.size() > 0) begin
          cur_hdr = header_q.pop_front();
          s_axis_tdata <= cur_hdr.data;
          s_axis_tuser <= cur_hdr.cmd;
          nv = 1'b1;
          gap_left = draw_wait(src_calm);
        end
      end
      s_axis_tvalid <= nv;
    end
  end

  // Input acceptance: predict the result of every accepted transaction.
  always @(posedge clk_i) begin : accept_proc
    out_data_t want;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      want = predict_verdict(cur_hdr);
      verdict_q.push_back(want);
      accepted_cnt++;
      sent = 1'b1;
      if (cur_hdr.cmd == CMD_ADD) n_add++;
      if (want.table_full) n_full++;
      if (want.matched) n_match++;
      if (want.verdict) n_drop++;
      if (want.log_header) n_log++;
    end
  end

  // Sink side: random stall before each output transaction.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (took) begin
        took = 1'b0;
        stall_left = draw_wait(snk_calm);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: compare each output transaction with the oldest prediction.
  always @(posedge clk_i) begin : monitor_proc
    out_data_t got;
    out_data_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got  = m_axis_tdata;
      took = 1'b1;
      if (verdict_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: result %h arrived with no prediction pending", $realtime, got);
      end else begin
        want = verdict_q.pop_front();
        checked_cnt++;
        if (got.verdict !== want.verdict || got.log_header !== want.log_header ||
            got.matched !== want.matched || got.rule_slot !== want.rule_slot ||
            got.table_full !== want.table_full) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: result %0d expected v=%0d log=%0d m=%0d slot=%0d full=%0d, got v=%0d log=%0d m=%0d slot=%0d full=%0d",
                     $realtime, checked_cnt, want.verdict, want.log_header,
                     want.matched, want.rule_slot, want.table_full, got.verdict,
                     got.log_header, got.matched, got.rule_slot, got.table_full);
        end
      end
    end
  end

  // Stimulus sequence and end of run.
  initial begin : stim_proc
    logic phase_en [PHASES];
    phase_en = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Filtering is off after reset: everything is accepted without a match.
    push_item(CMD_CLASSIFY, hdr_fields('0, '0, 8'h00, 1'b0, 1'b0, 1'b0, ACT_ACCEPT));
    push_item(CMD_CLASSIFY, hdr_fields('1, '1, 8'hFF, 1'b1, 1'b1, 1'b1, ACT_UNUSED));
    set_filter(1'b1);

    // Empty table, then one rule of each kind and action.
    push_item(CMD_CLASSIFY, hdr_fields(32'h0A00_0001, 32'hC0A8_0001, 8'd6,
                                       1'b0, 1'b0, 1'b0, ACT_DROP));
    push_item(CMD_ADD, hdr_fields('1, '1, 8'hFF, 1'b0, 1'b0, 1'b0, ACT_ACCEPT));
    push_item(CMD_ADD, hdr_fields('1, 32'h1, 8'h0, 1'b1, 1'b0, 1'b0, ACT_DROP));
    push_item(CMD_ADD, hdr_fields(32'h1, '0, 8'h0, 1'b0, 1'b1, 1'b0, ACT_LOG));
    push_item(CMD_ADD, hdr_fields('0, '0, 8'hFF, 1'b0, 1'b0, 1'b1, ACT_UNUSED));
    push_item(CMD_ADD, hdr_fields('0, '1, 8'h00, 1'b1, 1'b1, 1'b1, ACT_DROP));
    push_item(CMD_CLASSIFY, hdr_fields('1, 32'h1, 8'd6, 1'b0, 1'b0, 1'b0, ACT_ACCEPT));
    push_item(CMD_CLASSIFY, hdr_fields(32'h1, '0, 8'd6, 1'b0, 1'b0, 1'b0, ACT_ACCEPT));
    // A hit on the unused action falls through to the catch-all rule.
    push_item(CMD_CLASSIFY, hdr_fields(32'h5, 32'h5, 8'hFF, 1'b0, 1'b0, 1'b0, ACT_ACCEPT));
    push_item(CMD_CLASSIFY, hdr_fields('0, '1, 8'h00, 1'b0, 1'b0, 1'b0, ACT_ACCEPT));
    push_item(CMD_CLASSIFY, hdr_fields('0, '1, 8'h01, 1'b0, 1'b0, 1'b0, ACT_ACCEPT));
    push_item(CMD_CLASSIFY, hdr_fields('1, '0, 8'hFF, 1'b1, 1'b1, 1'b1, ACT_DROP));

    // Fill the table, hit the top slot, then overflow it.
    while (gen_rules.size() < TABLE_DEPTH - 1) push_item(CMD_ADD, make_rule());
    push_item(CMD_ADD, hdr_fields(32'h1234_5678, 32'h9ABC_DEF0, 8'd17,
                                  1'b1, 1'b1, 1'b1, ACT_LOG));
    push_item(CMD_CLASSIFY, hdr_fields(32'h1234_5678, 32'h9ABC_DEF0, 8'd17,
                                       1'b0, 1'b0, 1'b0, ACT_ACCEPT));
    push_item(CMD_ADD, make_rule());

    // Random phases with the filter switched on and off between them.
    for (int p = 0; p < PHASES; p++) begin
      set_filter(phase_en[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 9) == 0) push_item(CMD_ADD, make_rule());
        else push_item(CMD_CLASSIFY, make_packet());
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      err_cnt += verdict_q.size();
      $display("%0d predicted results never arrived", verdict_q.size());
    end
    $display("Checked %0d results for %0d transactions: %0d rule adds (%0d refused, table full), %0d classifies.",
             checked_cnt, accepted_cnt, n_add, n_full, accepted_cnt - n_add);
    $display("Classify outcomes: %0d rule hits, %0d drops, %0d logged; %0d enable writes.",
             n_match, n_drop, n_log, cfg_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Timeout waiting for results");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
